### design/iir_direct_form_one_defines.svh
// assertion macros for the direct form i filter
`ifndef IIR_DIRECT_FORM_ONE_DEFINES_SVH
`define IIR_DIRECT_FORM_ONE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define IIRDF1_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define IIRDF1_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/iirdf1_pkg.sv
// constants and types shared by the direct form i filter
`default_nettype none

package iirdf1_pkg;

	// filter order, 1 to 3
	localparam int ORDER = 2;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 32;
	localparam int FRAC_W   = 27;
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	// seven products at most, plus headroom
	localparam int ACC_W    = PROD_W + 4;

	localparam int NUM_REGS = 7;
	localparam int IDX_W    = 3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	// register indexes
	localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_A_BASE = 3'd3;

	localparam coef_t COEF_ONE = coef_t'(134217728);

	localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_W - 1);
	localparam acc_t SAT_HI = acc_t'(32767);
	localparam acc_t SAT_LO = -acc_t'(32768);
	localparam sample_t SAMPLE_MAX = sample_t'(32767);
	localparam sample_t SAMPLE_MIN = sample_t'(-32768);

	// reset value of a coefficient register
	function automatic coef_t coef_reset(input int idx);
		return (idx == int'(REG_B0)) ? COEF_ONE : '0;
	endfunction

endpackage

`default_nettype wire

### design/iir_direct_form_one.sv
// direct form i iir filter with one shared multiply-accumulate unit
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+------------------------
//  in       | in  | in_valid / in_stall | sample_in  (s16)
//  out      | out | out_valid/out_stall | sample_out (s16)
//  cfg      | in  | cfg_we              | cfg_index, cfg_data (s32)
//
// one word is worked on at a time; in_stall is high while the sequencer is not idle:
// one 32x16 multiplier is stepped over the 2*ORDER+1 taps, then a drain
// step for the last product and a round/saturate step
// the result sits in an output register; a stalled output holds the
// block in its rounding state until the previous word is taken
// asynchronous reset clears histories, restores b0 = 1.0, others zero
`default_nettype none
`include "iir_direct_form_one_defines.svh"

module iir_direct_form_one
	import iirdf1_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire  signed [SAMPLE_W-1:0] sample_in,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic signed [SAMPLE_W-1:0] sample_out,
	input  wire                     cfg_we,
	input  wire         [IDX_W-1:0] cfg_index,
	input  wire         [COEF_W-1:0] cfg_data
);

	// sequencer codes
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MAC   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_ROUND = 2'd3;

	logic [1:0] state_q;
	logic [1:0] k_q;        // tap number
	logic       fb_q;       // feedback half of the tap
	sample_t    x_q;        // current input word

	coef_t   coef_q [NUM_REGS];
	sample_t xh_q [ORDER];  // input history, newest first (rotated during mac)
	sample_t yh_q [ORDER];  // output history, newest first

	prod_t prod_s1;
	logic  sub_s1;
	logic  pv_s1;
	acc_t  acc_q;

	logic [IDX_W-1:0] coef_idx;
	coef_t   coef_sel;
	sample_t mul_sample;
	prod_t   prod_w;
	acc_t    rnd_w;
	sample_t sat_w;
	logic    in_acc;
	logic    out_take;
	logic    round_done;
	logic    last_tap;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;
	assign round_done = (state_q == ST_ROUND) && (!out_valid || !out_stall);
	assign last_tap = fb_q && (k_q == 2'(ORDER));

	// operand selection for the shared multiplier
	always_comb begin
		coef_idx = fb_q ? (IDX_W'(k_q) + REG_A_BASE) : IDX_W'(k_q);
		coef_sel = coef_q[coef_idx];
		if (k_q == 2'd0) begin
			mul_sample = x_q;
		end else if (fb_q) begin
			mul_sample = yh_q[0];
		end else begin
			mul_sample = xh_q[0];
		end
		prod_w = coef_sel * mul_sample;
	end

	// round half up, then clamp to 16 bits
	always_comb begin
		rnd_w = (acc_q + ROUND_HALF) >>> FRAC_W;
		if (rnd_w > SAT_HI) begin
			sat_w = SAMPLE_MAX;
		end else if (rnd_w < SAT_LO) begin
			sat_w = SAMPLE_MIN;
		end else begin
			sat_w = rnd_w[SAMPLE_W-1:0];
		end
	end

	// coefficient registers; index seven is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coef_q[i] <= coef_reset(i);
			end
		end else if (cfg_we && (cfg_index < IDX_W'(NUM_REGS))) begin
			coef_q[cfg_index] <= coef_t'(cfg_data);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			fb_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_MAC;
						k_q     <= '0;
						fb_q    <= 1'b0;
					end
				end
				ST_MAC: begin
					if (k_q == 2'd0) begin
						k_q  <= 2'd1;
						fb_q <= 1'b0;
					end else if (!fb_q) begin
						fb_q <= 1'b1;
					end else if (last_tap) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q  <= k_q + 2'd1;
						fb_q <= 1'b0;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (round_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= sample_in;
		end
	end

	// product register and its valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= (state_q == ST_MAC);
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_w;
		sub_s1  <= fb_q && (k_q != 2'd0);
	end

	// accumulator, cleared on accept
	always_ff @(posedge clk) begin
		if (in_acc) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			if (sub_s1) begin
				acc_q <= acc_q - acc_t'(prod_s1);
			end else begin
				acc_q <= acc_q + acc_t'(prod_s1);
			end
		end
	end

	// histories: rotate after each read, shift in on completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ORDER; i++) begin
				xh_q[i] <= '0;
				yh_q[i] <= '0;
			end
		end else if (state_q == ST_MAC && k_q != 2'd0) begin
			if (!fb_q) begin
				for (int i = 0; i < ORDER - 1; i++) begin
					xh_q[i] <= xh_q[i+1];
				end
				xh_q[ORDER-1] <= xh_q[0];
			end else begin
				for (int i = 0; i < ORDER - 1; i++) begin
					yh_q[i] <= yh_q[i+1];
				end
				yh_q[ORDER-1] <= yh_q[0];
			end
		end else if (round_done) begin
			for (int i = 1; i < ORDER; i++) begin
				xh_q[i] <= xh_q[i-1];
				yh_q[i] <= yh_q[i-1];
			end
			xh_q[0] <= x_q;
			yh_q[0] <= sat_w;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (round_done) begin
			out_valid <= 1'b1;
		end else if (out_take) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (round_done) begin
			sample_out <= sat_w;
		end
	end

	`IIRDF1_ASSERT_NEXT(a_accept_starts_mac, clk, arst_n, in_acc,
		state_q == ST_MAC && k_q == 2'd0, "accept did not start the tap sequence")
	`IIRDF1_ASSERT_NOW(a_tap_in_range, clk, arst_n, state_q == ST_MAC,
		k_q <= 2'(ORDER), "tap counter ran past the order")
	`IIRDF1_ASSERT_NOW(a_result_from_round, clk, arst_n, $rose(out_valid),
		$past(state_q) == ST_ROUND, "result appeared outside the rounding step")
	`IIRDF1_ASSERT_NEXT(a_round_waits, clk, arst_n,
		state_q == ST_ROUND && out_valid && out_stall,
		state_q == ST_ROUND, "rounding step left while output was full")

endmodule

`default_nettype wire
